/* src/fermi_level_bisection_macros.svh */
// Assertion macros shared by the Fermi level bisection RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FERMI_LEVEL_BISECTION_MACROS_SVH
`define FERMI_LEVEL_BISECTION_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define FLB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
// condition must never be true outside reset
`define FLB_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define FLB_ASSERT(label, clk, rst, prop)
`define FLB_ASSERT_NEVER(label, clk, rst, cond)
`endif

`endif

/* src/flb_pkg.sv */
// Types and constants of the Fermi level bisection block.
// No dependencies; used by flb_occ, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package flb_pkg;

   localparam int E_W   = 48;  // energy, signed Q16.32
   localparam int MU_W  = 50;  // chemical potential and bracket points, signed
   localparam int D_W   = 51;  // energy minus mu, signed
   localparam int KT_W  = 41;  // kT, Q9.32
   localparam int NEL_W = 39;  // electron count, Q7.32
   localparam int TOL_W = 33;
   localparam int LIM_W = 6;
   localparam int OCC_W = 33;  // occupation, Q1.32 up to one
   localparam int SUM_W = 38;  // up to 63 full states
   localparam int F_W   = 40;  // signed count error
   localparam int Y_W   = 37;  // |d|/kT in Q5.32
   localparam int RV_W  = 48;
   localparam int CSR_W = 41;

   localparam int TAYLOR_TERMS = 24;
   localparam int SQUARINGS    = 6;
   localparam int FDIV_STEPS   = 33;

   localparam logic [OCC_W-1:0] ONE_Q32 = 33'h1_0000_0000;
   localparam logic [63:0]      ONE_Q62 = 64'h4000_0000_0000_0000;

   localparam logic signed [D_W-1:0]  STEP_MARGIN       = 51'sd4295;
   localparam logic signed [MU_W-1:0] LOW_MARGIN        = 50'sd4294967;
   localparam logic signed [MU_W-1:0] NO_ELECTRON_BOUND = 50'sd42949672960000;
   localparam logic signed [MU_W-1:0] MU_MAX48          = 50'sd140737488355327;
   localparam logic signed [MU_W-1:0] MU_MIN48          = -50'sd140737488355328;

   localparam logic signed [E_W-1:0] E_MOST_POS = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [E_W-1:0] E_MOST_NEG = 48'sh8000_0000_0000;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd32;
   localparam logic [TOL_W-1:0] TOL_RESET   = 33'd1;

   typedef enum logic [1:0] {
      CSR_ELECTRON_COUNT   = 2'd0,
      CSR_SMEARING_WIDTH   = 2'd1,
      CSR_OCCUPIED_LIMIT   = 2'd2,
      CSR_CHARGE_TOLERANCE = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CONVERGED      = 2'd0,
      ST_ITER_LIMIT     = 2'd1,
      ST_NO_SIGN_CHANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      PH_UPPER,
      PH_LOWER,
      PH_BISECT
   } phase_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_SETUP,
      S_FILL_RD,
      S_FILL_GO,
      S_FILL_OCC,
      S_EVAL,
      S_BSTEP,
      S_EMIT_RD,
      S_EMIT_LD,
      S_EMIT_WAIT,
      S_MU_WAIT
   } flb_state_type;

   typedef enum logic [3:0] {
      OCC_IDLE,
      OCC_YDIV,
      OCC_TMUL,
      OCC_TWAIT,
      OCC_TDIV,
      OCC_TACC,
      OCC_SQMUL,
      OCC_SQWAIT,
      OCC_FDIV,
      OCC_FIN,
      OCC_DONE
   } occ_state_type;

endpackage

`default_nettype wire

/* src/flb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module flb_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

/* src/flb_mul.sv */
// Multi-cycle Q.62 multiplier: (a*b) >> 62 from four 32x32 partial products.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
`default_nettype none

module flb_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start_i,
   input  wire logic [63:0] a_i,
   input  wire logic [63:0] b_i,
   output logic             done_o,
   output logic [63:0]      result_o
);

   logic [63:0]  a_ff, b_ff;
   logic [2:0]   step_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [63:0]  pp_ff;
   logic [127:0] acc_ff;
   logic [31:0]  a_sel, b_sel;
   logic [127:0] pp_shift;

   // step 0: al*bl, 1: ah*bl, 2: al*bh, 3: ah*bh
   assign a_sel = step_ff[0] ? a_ff[63:32] : a_ff[31:0];
   assign b_sel = step_ff[1] ? b_ff[63:32] : b_ff[31:0];

   // product in pp_ff belongs to the previous step
   always_comb begin
      case (step_ff)
         3'd1:    pp_shift = {64'b0, pp_ff};
         3'd4:    pp_shift = {pp_ff, 64'b0};
         default: pp_shift = {32'b0, pp_ff, 32'b0};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start_i && !busy_ff) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 3'd1;
            if (step_ff == 3'd4) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_i && !busy_ff) begin
         a_ff   <= a_i;
         b_ff   <= b_i;
         acc_ff <= '0;
      end else if (busy_ff) begin
         pp_ff <= 64'(a_sel) * 64'(b_sel);
         if (step_ff != 3'd0) begin
            acc_ff <= acc_ff + pp_shift;
         end
      end
   end

   assign done_o   = done_ff;
   assign result_o = acc_ff[125:62];

endmodule

`default_nettype wire

/* src/flb_occ.sv */
// Fermi-Dirac occupation unit: divides |E-mu| by kT, runs the exp series on
// the shared multiplier, squares, and divides to round(e/(1+e)). Uses flb_pkg, flb_mul.
`timescale 1ns / 1ps
`default_nettype none
`include "fermi_level_bisection_macros.svh"

module flb_occ (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start_i,
   input  wire logic signed [flb_pkg::E_W-1:0]  energy_i,
   input  wire logic signed [flb_pkg::MU_W-1:0] mu_i,
   input  wire logic [flb_pkg::KT_W-1:0]        kt_i,
   output logic                                 done_o,
   output logic [flb_pkg::OCC_W-1:0]            occ_o
);

   import flb_pkg::*;

   occ_state_type state_ff, state_in;

   logic signed [D_W-1:0] d;
   logic [D_W-1:0]        a;
   logic                  d_pos;
   logic                  is_big;

   logic                  pos_ff;
   logic [KT_W-1:0]       kt_ff;
   logic [41:0]           rem_ff;
   logic [Y_W-1:0]        num_ff;
   logic [Y_W-1:0]        y_ff;
   logic [5:0]            cnt_ff;
   logic [4:0]            k_ff;
   logic [63:0]           term_ff, sum_ff;
   logic [63:0]           dq_ff;
   logic [4:0]            dr_ff;
   logic [63:0]           den_ff, frem_ff;
   logic [32:0]           quo_ff;
   logic [OCC_W-1:0]      occ_ff;

   logic [41:0]           y_r2;
   logic                  y_ge;
   logic [5:0]            td_r;
   logic [63:0]           td_q;
   logic [63:0]           fd_r;
   logic                  fd_ge;
   logic [33:0]           g_round;
   logic [OCC_W-1:0]      g;
   logic [63:0]           z;

   logic                  mul_start;
   logic [63:0]           mul_a, mul_b, mul_result;
   logic                  mul_done;

   assign d      = D_W'(energy_i) - D_W'(mu_i);
   assign a      = d[D_W-1] ? D_W'(-d) : D_W'(d);
   assign d_pos  = !d[D_W-1] && (d != '0);
   assign is_big = a >= D_W'({kt_i, 5'b0});

   assign z = {3'b0, y_ff, 24'b0};

   assign y_r2 = {rem_ff[40:0], num_ff[Y_W-1]};
   assign y_ge = y_r2 >= 42'(kt_ff);

   // eight restoring steps per cycle against the small divisor k
   always_comb begin
      td_r = {1'b0, dr_ff};
      td_q = dq_ff;
      for (int j = 0; j < 8; j++) begin
         td_r = {td_r[4:0], td_q[63]};
         td_q = {td_q[62:0], 1'b0};
         if (td_r >= {1'b0, k_ff}) begin
            td_r    = td_r - {1'b0, k_ff};
            td_q[0] = 1'b1;
         end
      end
   end

   assign fd_r  = {frem_ff[62:0], 1'b0};
   assign fd_ge = fd_r >= den_ff;

   assign g_round = 34'(quo_ff) + 34'd1;
   assign g       = g_round[33:1];

   assign mul_a = (state_ff == OCC_SQMUL) ? sum_ff : term_ff;
   assign mul_b = (state_ff == OCC_SQMUL) ? sum_ff : z;

   flb_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .start_i  (mul_start),
      .a_i      (mul_a),
      .b_i      (mul_b),
      .done_o   (mul_done),
      .result_o (mul_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OCC_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mul_start = 1'b0;
      unique case (state_ff)
         OCC_IDLE: begin
            if (start_i) begin
               state_in = ((kt_i == '0) || is_big) ? OCC_DONE : OCC_YDIV;
            end
         end
         OCC_YDIV: begin
            if (cnt_ff == 6'(Y_W - 1)) state_in = OCC_TMUL;
         end
         OCC_TMUL: begin
            mul_start = 1'b1;
            state_in  = OCC_TWAIT;
         end
         OCC_TWAIT: begin
            if (mul_done) state_in = OCC_TDIV;
         end
         OCC_TDIV: begin
            if (cnt_ff == 6'd7) state_in = OCC_TACC;
         end
         OCC_TACC: begin
            state_in = (k_ff == 5'(TAYLOR_TERMS)) ? OCC_SQMUL : OCC_TMUL;
         end
         OCC_SQMUL: begin
            mul_start = 1'b1;
            state_in  = OCC_SQWAIT;
         end
         OCC_SQWAIT: begin
            if (mul_done) begin
               state_in = (cnt_ff == 6'(SQUARINGS - 1)) ? OCC_FDIV : OCC_SQMUL;
            end
         end
         OCC_FDIV: begin
            if (cnt_ff == 6'(FDIV_STEPS - 1)) state_in = OCC_FIN;
         end
         OCC_FIN:  state_in = OCC_DONE;
         OCC_DONE: state_in = OCC_IDLE;
         default:  state_in = OCC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         OCC_IDLE: begin
            pos_ff  <= d_pos;
            kt_ff   <= kt_i;
            rem_ff  <= 42'(a >> 5);
            num_ff  <= {a[4:0], 32'b0};
            y_ff    <= '0;
            cnt_ff  <= '0;
            k_ff    <= 5'd1;
            term_ff <= ONE_Q62;
            sum_ff  <= ONE_Q62;
            if (kt_i == '0) begin
               occ_ff <= (d > STEP_MARGIN) ? '0 : ONE_Q32;
            end else begin
               occ_ff <= d_pos ? '0 : ONE_Q32;
            end
         end
         OCC_YDIV: begin
            rem_ff <= y_ge ? (y_r2 - 42'(kt_ff)) : y_r2;
            y_ff   <= {y_ff[Y_W-2:0], y_ge};
            num_ff <= {num_ff[Y_W-2:0], 1'b0};
            cnt_ff <= (cnt_ff == 6'(Y_W - 1)) ? '0 : cnt_ff + 6'd1;
         end
         OCC_TWAIT: begin
            dq_ff <= mul_result;
            dr_ff <= '0;
         end
         OCC_TDIV: begin
            dq_ff  <= td_q;
            dr_ff  <= td_r[4:0];
            cnt_ff <= (cnt_ff == 6'd7) ? '0 : cnt_ff + 6'd1;
         end
         OCC_TACC: begin
            term_ff <= dq_ff;
            sum_ff  <= k_ff[0] ? (sum_ff - dq_ff) : (sum_ff + dq_ff);
            k_ff    <= k_ff + 5'd1;
         end
         OCC_SQWAIT: begin
            if (mul_done) begin
               sum_ff  <= mul_result;
               den_ff  <= ONE_Q62 + mul_result;
               frem_ff <= mul_result;
               quo_ff  <= '0;
               cnt_ff  <= (cnt_ff == 6'(SQUARINGS - 1)) ? '0 : cnt_ff + 6'd1;
            end
         end
         OCC_FDIV: begin
            frem_ff <= fd_ge ? (fd_r - den_ff) : fd_r;
            quo_ff  <= {quo_ff[31:0], fd_ge};
            cnt_ff  <= cnt_ff + 6'd1;
         end
         OCC_FIN: begin
            occ_ff <= pos_ff ? g : (ONE_Q32 - g);
         end
         default: begin
         end
      endcase
   end

   assign done_o = (state_ff == OCC_DONE);
   assign occ_o  = occ_ff;

   `FLB_ASSERT(a_occ_range, clock, reset, done_o |-> (occ_o <= ONE_Q32))
   `FLB_ASSERT(a_start_when_idle, clock, reset, start_i |-> (state_ff == OCC_IDLE))
   `FLB_ASSERT(a_term_index, clock, reset, (state_ff == OCC_TDIV) |-> (k_ff != 5'd0 && k_ff <= 5'(TAYLOR_TERMS)))

endmodule

`default_nettype wire

/* src/fermi_level_bisection.sv */
// Fermi level search by bisection: top level with load, solve and emit sequencer.
// Depends on flb_pkg, flb_ram, flb_occ and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "fermi_level_bisection_macros.svh"

// Energies (signed Q16.32) load one per cycle on the req_ channel. The transfer
// that carries req_last_energy starts the solve: the block stops taking input,
// brackets the Fermi level mu, and bisects until the summed occupations match
// the electron count. It then emits one occupation transfer per loaded state
// (index order) and a final mu transfer with rsp_last_result set; all of them
// carry the same status. A solve evaluates the occupations up to
// MAX_ITERATIONS + 2 times; each pass visits every loaded state. The time
// that a state at finite kT spends in the occupation unit is set by the
// shared 32x32 multiplier (30 passes for the exp series and squarings), the
// serial divide of the series terms by their index, and the one-bit-per-cycle
// divisions for |E-mu|/kT and e/(1+e). States at or beyond occupied_limit
// skip the occupation unit; for states far from mu and for kT = 0 it goes
// straight to its result. Energies beyond MAX_STATES are dropped. Configuration
// on csr_ is always ready and should be written only while the block is idle.
module fermi_level_bisection #(
   parameter int MAX_STATES     = 32,
   parameter int MAX_ITERATIONS = 100
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // energy input
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [flb_pkg::E_W-1:0]   req_energy,
   input  wire logic                             req_last_energy,
   // results
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic                                  rsp_kind,
   output logic [4:0]                            rsp_state_index,
   output logic signed [flb_pkg::RV_W-1:0]       rsp_result_value,
   output logic [1:0]                            rsp_status,
   output logic                                  rsp_last_result,
   // configuration writes
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [flb_pkg::CSR_W-1:0]        csr_data
);

   import flb_pkg::*;

   localparam int CNT_W  = $clog2(MAX_STATES + 1);
   localparam int ADDR_W = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
   localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

   flb_state_type state_ff, state_in;

   // configuration registers
   logic [NEL_W-1:0] nel_ff;
   logic [KT_W-1:0]  kt_ff;
   logic [LIM_W-1:0] lim_ff;
   logic [TOL_W-1:0] tol_ff;

   // load state
   logic [CNT_W-1:0]      cnt_ff;
   logic signed [E_W-1:0] emin_ff, emax_ff;

   // solve state
   logic signed [MU_W-1:0] mu1_ff, mu2_ff, mu_ff, trial_ff, dmu_ff;
   logic signed [F_W-1:0]  f2_ff;
   logic [SUM_W-1:0]       sum_ff;
   logic [CNT_W-1:0]       idx_ff;
   logic [ITER_W-1:0]      iter_ff;
   phase_type              phase_ff;
   status_type             status_ff;
   logic                   full_ff;

   // result register
   logic                   rsp_valid_ff;
   logic                   rsp_kind_ff;
   logic [4:0]             rsp_index_ff;
   logic signed [RV_W-1:0] rsp_value_ff;
   status_type             rsp_status_ff;
   logic                   rsp_last_ff;

   // strobes and datapath wires
   logic                   e_we;
   logic                   occ_start, occ_done, occ_wr;
   logic [OCC_W-1:0]       occ_value, occ_wdata, occ_rdata;
   logic signed [E_W-1:0]  e_rdata;
   logic                   occupiable, last_idx;

   logic [44:0]            kt10;
   logic signed [MU_W-1:0] mu1_calc, mu2_calc, half_dmu, mu_sat;
   logic                   all_full;
   logic signed [F_W-1:0]  f_val;
   logic [F_W-1:0]         f_abs;
   logic                   f_lt_tol, f_gt_tol, f_nonpos, same_sign, iter_left;

   assign req_ready = (state_ff == S_LOAD);
   assign csr_ready = 1'b1;

   assign e_we = req_valid && req_ready && (cnt_ff < CNT_W'(MAX_STATES));

   assign occupiable = 8'(idx_ff) < 8'(lim_ff);
   assign last_idx   = CNT_W'(idx_ff + 1'b1) == cnt_ff;

   // bracket: [emin - 0.001, emax + 10 kT], or +/-10000 with no electrons
   assign kt10     = {1'b0, kt_ff, 3'b0} + {3'b0, kt_ff, 1'b0};
   assign mu1_calc = (nel_ff == '0) ? -NO_ELECTRON_BOUND : (MU_W'(emin_ff) - LOW_MARGIN);
   assign mu2_calc = (nel_ff == '0) ? NO_ELECTRON_BOUND
                                    : (MU_W'(emax_ff) + $signed(MU_W'(kt10)));
   assign all_full = 40'({cnt_ff, 32'b0}) <= 40'(nel_ff);

   // count error of the pass just finished
   assign f_val     = $signed(F_W'(sum_ff)) - $signed(F_W'(nel_ff));
   assign f_abs     = f_val[F_W-1] ? F_W'(-f_val) : F_W'(f_val);
   assign f_lt_tol  = f_abs < F_W'(tol_ff);
   assign f_gt_tol  = f_abs > F_W'(tol_ff);
   assign f_nonpos  = f_val[F_W-1] || (f_val == '0);
   assign same_sign = (f_val != '0) && (f2_ff != '0) && (f_val[F_W-1] == f2_ff[F_W-1]);
   assign iter_left = iter_ff < ITER_W'(MAX_ITERATIONS);

   // halve the step, truncating toward zero
   assign half_dmu = (dmu_ff + $signed(MU_W'(dmu_ff[MU_W-1]))) >>> 1;

   assign mu_sat = (mu_ff > MU_MAX48) ? MU_MAX48 : ((mu_ff < MU_MIN48) ? MU_MIN48 : mu_ff);

   flb_ram #(.WIDTH(E_W), .DEPTH(MAX_STATES)) u_energy_ram (
      .clock (clock),
      .we    (e_we),
      .waddr (cnt_ff[ADDR_W-1:0]),
      .wdata (req_energy),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (e_rdata)
   );

   flb_ram #(.WIDTH(OCC_W), .DEPTH(MAX_STATES)) u_occ_ram (
      .clock (clock),
      .we    (occ_wr),
      .waddr (idx_ff[ADDR_W-1:0]),
      .wdata (occ_wdata),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (occ_rdata)
   );

   flb_occ u_occ (
      .clock    (clock),
      .reset    (reset),
      .start_i  (occ_start),
      .energy_i (e_rdata),
      .mu_i     (trial_ff),
      .kt_i     (kt_ff),
      .done_o   (occ_done),
      .occ_o    (occ_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      occ_start = 1'b0;
      occ_wr    = 1'b0;
      occ_wdata = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid && req_last_energy) state_in = S_SETUP;
         end
         S_SETUP: begin
            state_in = all_full ? S_EMIT_RD : S_FILL_RD;
         end
         S_FILL_RD: state_in = S_FILL_GO;
         S_FILL_GO: begin
            if (occupiable) begin
               occ_start = 1'b1;
               state_in  = S_FILL_OCC;
            end else begin
               occ_wr   = 1'b1;
               state_in = last_idx ? S_EVAL : S_FILL_RD;
            end
         end
         S_FILL_OCC: begin
            if (occ_done) begin
               occ_wr    = 1'b1;
               occ_wdata = occ_value;
               state_in  = last_idx ? S_EVAL : S_FILL_RD;
            end
         end
         S_EVAL: begin
            unique case (phase_ff)
               PH_UPPER: state_in = f_lt_tol ? S_EMIT_RD : S_FILL_RD;
               PH_LOWER: state_in = (f_lt_tol || same_sign) ? S_EMIT_RD : S_BSTEP;
               PH_BISECT: state_in = (iter_left && f_gt_tol) ? S_BSTEP : S_EMIT_RD;
               default: state_in = S_EMIT_RD;
            endcase
         end
         S_BSTEP:   state_in = S_FILL_RD;
         S_EMIT_RD: state_in = S_EMIT_LD;
         S_EMIT_LD: state_in = S_EMIT_WAIT;
         S_EMIT_WAIT: begin
            if (rsp_ready) state_in = last_idx ? S_MU_WAIT : S_EMIT_RD;
         end
         S_MU_WAIT: begin
            if (rsp_ready) state_in = S_LOAD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         nel_ff <= '0;
         kt_ff  <= '0;
         lim_ff <= LIMIT_RESET;
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_ELECTRON_COUNT:   nel_ff <= csr_data[NEL_W-1:0];
            CSR_SMEARING_WIDTH:   kt_ff  <= csr_data[KT_W-1:0];
            CSR_OCCUPIED_LIMIT:   lim_ff <= csr_data[LIM_W-1:0];
            CSR_CHARGE_TOLERANCE: tol_ff <= csr_data[TOL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // load state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         emin_ff      <= E_MOST_POS;
         emax_ff      <= E_MOST_NEG;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (e_we) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (req_energy < emin_ff) emin_ff <= req_energy;
            if (req_energy > emax_ff) emax_ff <= req_energy;
         end
         if (state_ff == S_EMIT_LD) begin
            rsp_valid_ff <= 1'b1;
         end else if (state_ff == S_EMIT_WAIT && rsp_ready) begin
            // drop straight into the mu item after the last occupation
            rsp_valid_ff <= last_idx;
         end else if (state_ff == S_MU_WAIT && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
            cnt_ff       <= '0;
            emin_ff      <= E_MOST_POS;
            emax_ff      <= E_MOST_NEG;
         end
      end
   end

   // solve datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_SETUP: begin
            mu1_ff    <= mu1_calc;
            mu2_ff    <= mu2_calc;
            mu_ff     <= mu2_calc;
            trial_ff  <= mu2_calc;
            full_ff   <= all_full;
            status_ff <= ST_CONVERGED;
            phase_ff  <= PH_UPPER;
            idx_ff    <= '0;
            sum_ff    <= '0;
         end
         S_FILL_GO: begin
            if (!occupiable) begin
               idx_ff <= last_idx ? idx_ff : idx_ff + 1'b1;
            end
         end
         S_FILL_OCC: begin
            if (occ_done) begin
               sum_ff <= sum_ff + SUM_W'(occ_value);
               idx_ff <= last_idx ? idx_ff : idx_ff + 1'b1;
            end
         end
         S_EVAL: begin
            idx_ff <= '0;
            sum_ff <= '0;
            unique case (phase_ff)
               PH_UPPER: begin
                  f2_ff    <= f_val;
                  mu_ff    <= mu2_ff;
                  trial_ff <= mu1_ff;
                  phase_ff <= PH_LOWER;
               end
               PH_LOWER: begin
                  iter_ff <= '0;
                  if (f_lt_tol) begin
                     mu_ff <= mu1_ff;
                  end else if (same_sign) begin
                     mu_ff     <= mu1_ff;
                     status_ff <= ST_NO_SIGN_CHANGE;
                  end else if (f_val[F_W-1]) begin
                     mu_ff  <= mu1_ff;
                     dmu_ff <= mu2_ff - mu1_ff;
                  end else begin
                     mu_ff  <= mu2_ff;
                     dmu_ff <= mu1_ff - mu2_ff;
                  end
               end
               PH_BISECT: begin
                  if (f_nonpos) mu_ff <= trial_ff;
                  if (!(iter_left && f_gt_tol)) begin
                     status_ff <= f_gt_tol ? ST_ITER_LIMIT : ST_CONVERGED;
                  end
               end
               default: begin
               end
            endcase
         end
         S_BSTEP: begin
            iter_ff  <= iter_ff + 1'b1;
            dmu_ff   <= half_dmu;
            trial_ff <= mu_ff + half_dmu;
            phase_ff <= PH_BISECT;
            idx_ff   <= '0;
            sum_ff   <= '0;
         end
         S_EMIT_LD: begin
            rsp_kind_ff   <= 1'b0;
            rsp_index_ff  <= 5'(idx_ff);
            rsp_value_ff  <= full_ff ? RV_W'(ONE_Q32) : RV_W'(occ_rdata);
            rsp_status_ff <= status_ff;
            rsp_last_ff   <= 1'b0;
         end
         S_EMIT_WAIT: begin
            if (rsp_ready) begin
               if (last_idx) begin
                  rsp_kind_ff  <= 1'b1;
                  rsp_index_ff <= '0;
                  rsp_value_ff <= RV_W'(mu_sat);
                  rsp_last_ff  <= 1'b1;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_state_index  = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_last_result  = rsp_last_ff;

   `FLB_ASSERT_NEVER(a_no_load_while_emit, clock, reset, req_ready && rsp_valid)
   `FLB_ASSERT(a_last_is_mu, clock, reset, (rsp_valid && rsp_last_result) |-> rsp_kind)
   `FLB_ASSERT(a_ready_after_mu, clock, reset, (rsp_valid && rsp_ready && rsp_last_result) |=> req_ready)

endmodule

`default_nettype wire

/* test/fermi_level_bisection_test.sv */
// Self-checking testbench for fermi_level_bisection: a directed table, then random energy sets.
// Depends on flb_pkg and the fermi_level_bisection RTL; results are checked by an internal predictor.
`timescale 1ns / 1ps

module fermi_level_bisection_test;
   import flb_pkg::*;

   localparam longint ONE_OCC = 64'sd4294967296;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [E_W-1:0] req_energy = '0;
   logic req_last_energy = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_kind;
   logic [4:0] rsp_state_index;
   logic signed [RV_W-1:0] rsp_result_value;
   logic [1:0] rsp_status;
   logic rsp_last_result;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_data = '0;

   fermi_level_bisection uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_energy(req_energy), .req_last_energy(req_last_energy),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_state_index(rsp_state_index), .rsp_result_value(rsp_result_value),
      .rsp_status(rsp_status), .rsp_last_result(rsp_last_result),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // one expected result transfer
   typedef struct {
      logic                   kind;
      logic [4:0]             index;
      logic signed [RV_W-1:0] value;
      logic [1:0]             status;
      logic                   last;
   } fermi_result_type;

   fermi_result_type pending_results[$];
   int error_count = 0;

   // shadow copy of the configuration and the load state
   longint unsigned nel_q = 0, kt_q = 0, lim_q = 32, tol_q = 1;
   longint stored_energy[32];
   longint occ_now[32];
   int     loaded = 0;
   longint lowest_e = 64'sd140737488355327;
   longint highest_e = -64'sd140737488355328;

   // randomization of the handshakes
   bit no_gaps = 1'b0;
   bit hold_rsp = 1'b0;

   // ---------------- predictor ----------------

   // (a*b) >> 62 on Q.62 operands
   function automatic longint unsigned mul_fix62(longint unsigned a, longint unsigned b);
      logic [127:0] p;
      p = a * b;
      return p[125:62];
   endfunction

   // round(e/(1+e)) in Q0.32, e = exp(-a/kt), built from the series of exp(-y/64)
   function automatic longint unsigned logistic_tail(longint unsigned a, longint unsigned kt);
      longint unsigned q, r, h1, r2, h2, z, sum, term, den, rem, quo;
      q = a / kt;
      r = a % kt;
      h1 = (r << 16) / kt;
      r2 = (r << 16) % kt;
      h2 = (r2 << 16) / kt;
      z = ((q << 32) | (h1 << 16) | h2) << 24;
      sum = ONE_Q62;
      term = ONE_Q62;
      quo = 0;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
         term = mul_fix62(term, z) / longint'(k);
         if (k % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      for (int k = 0; k < SQUARINGS; k++) sum = mul_fix62(sum, sum);
      den = ONE_Q62 + sum;
      rem = sum;
      for (int k = 0; k < FDIV_STEPS; k++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | 1;
         end
      end
      return (quo + 1) >> 1;
   endfunction

   function automatic longint occupation_at(longint d);
      longint unsigned a, g;
      if (kt_q == 0) return (d > 4295) ? 0 : ONE_OCC;
      a = (d < 0) ? -d : d;
      g = (a >= 32 * kt_q) ? 0 : logistic_tail(a, kt_q);
      return (d > 0) ? longint'(g) : ONE_OCC - longint'(g);
   endfunction

   // fill occ_now at trial mu and return the count error
   function automatic longint count_error(longint mu, int n, int lim);
      longint sum;
      sum = 0;
      for (int i = 0; i < n; i++) begin
         occ_now[i] = (i < lim) ? occupation_at(stored_energy[i] - mu) : 0;
         sum += occ_now[i];
      end
      return sum - longint'(nel_q);
   endfunction

   function automatic longint magnitude_of(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // take one accepted energy; on the last one solve and queue the results
   task automatic predict_fermi_level(longint e, bit last_e);
      longint mu1, mu2, mu, f1, f2, f, dmu, trial, nel, tol;
      int n, lim, iter;
      logic [1:0] st;
      fermi_result_type r;
      if (loaded < 32) begin
         stored_energy[loaded] = e;
         loaded++;
         if (e < lowest_e) lowest_e = e;
         if (e > highest_e) highest_e = e;
      end
      if (!last_e) return;
      nel = longint'(nel_q);
      tol = longint'(tol_q);
      st = ST_CONVERGED;
      n = loaded;
      lim = (lim_q > n) ? n : int'(lim_q);
      mu1 = lowest_e - 4294967;
      mu2 = highest_e + 10 * longint'(kt_q);
      if (nel == 0) begin
         mu1 = -64'sd42949672960000;
         mu2 = 64'sd42949672960000;
      end
      if ((longint'(n) <<< 32) <= nel) begin
         for (int i = 0; i < n; i++) occ_now[i] = ONE_OCC;
         mu = mu2;
      end else begin
         f2 = count_error(mu2, n, lim);
         if (magnitude_of(f2) < tol) begin
            mu = mu2;
         end else begin
            f1 = count_error(mu1, n, lim);
            if (magnitude_of(f1) < tol) begin
               mu = mu1;
            end else if ((f1 > 0 && f2 > 0) || (f1 < 0 && f2 < 0)) begin
               mu = mu1;
               st = ST_NO_SIGN_CHANGE;
            end else begin
               if (f1 < 0) begin
                  mu = mu1;
                  dmu = mu2 - mu1;
               end else begin
                  mu = mu2;
                  dmu = mu1 - mu2;
               end
               iter = 0;
               do begin
                  iter++;
                  dmu = dmu / 2;
                  trial = mu + dmu;
                  f = count_error(trial, n, lim);
                  if (f <= 0) begin
                     mu = trial;
                     f = -f;
                  end
               end while (iter < 100 && f > tol);
               if (f > tol) st = ST_ITER_LIMIT;
            end
         end
      end
      for (int k = 0; k < n; k++) begin
         r.kind = 1'b0;
         r.index = k[4:0];
         r.value = occ_now[k][RV_W-1:0];
         r.status = st;
         r.last = 1'b0;
         pending_results.push_back(r);
      end
      // clamp mu into the 48-bit output range
      if (mu > 64'sd140737488355327) mu = 64'sd140737488355327;
      if (mu < -64'sd140737488355328) mu = -64'sd140737488355328;
      r.kind = 1'b1;
      r.index = '0;
      r.value = mu[RV_W-1:0];
      r.status = st;
      r.last = 1'b1;
      pending_results.push_back(r);
      loaded = 0;
      lowest_e = 64'sd140737488355327;
      highest_e = -64'sd140737488355328;
   endtask

   // ---------------- drivers ----------------

   // offer one register write and hold until it transfers; valid stays up
   task automatic write_csr(csr_index_type idx, longint unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_W-1:0];
      do @(posedge clock); while (!(csr_valid && csr_ready));
      case (idx)
         CSR_ELECTRON_COUNT: nel_q = value & ((64'd1 << 39) - 1);
         CSR_SMEARING_WIDTH: kt_q = value & ((64'd1 << 41) - 1);
         CSR_OCCUPIED_LIMIT: lim_q = value & 63;
         default: tol_q = value & ((64'd1 << 33) - 1);
      endcase
   endtask

   task automatic program_solver(longint unsigned nel, longint unsigned kt,
                                 longint unsigned lim, longint unsigned tol);
      write_csr(CSR_ELECTRON_COUNT, nel);
      write_csr(CSR_SMEARING_WIDTH, kt);
      write_csr(CSR_OCCUPIED_LIMIT, lim);
      write_csr(CSR_CHARGE_TOLERANCE, tol);
      csr_valid <= 1'b0;
   endtask

   // drop the input, hold off until every queued result has arrived, then settle
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic send_energy(logic signed [E_W-1:0] e, bit last_e);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_energy <= e;
      req_last_energy <= last_e;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_fermi_level(longint'(e), last_e);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   // compare each result transfer against the oldest expectation
   always @(posedge clock) begin
      fermi_result_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind=%0d index=%0d value=%0d", $realtime,
                     rsp_kind, rsp_state_index, rsp_result_value);
            error_count++;
         end else begin
            x = pending_results.pop_front();
            if (rsp_kind !== x.kind) begin
               $display("%0t: kind expected %0d actual %0d", $realtime, x.kind, rsp_kind);
               error_count++;
            end
            if (rsp_state_index !== x.index) begin
               $display("%0t: state_index expected %0d actual %0d", $realtime,
                        x.index, rsp_state_index);
               error_count++;
            end
            if (rsp_result_value !== x.value) begin
               $display("%0t: result_value expected %0d actual %0d", $realtime,
                        x.value, rsp_result_value);
               error_count++;
            end
            if (rsp_status !== x.status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        x.status, rsp_status);
               error_count++;
            end
            if (rsp_last_result !== x.last) begin
               $display("%0t: last_result expected %0d actual %0d", $realtime,
                        x.last, rsp_last_result);
               error_count++;
            end
         end
      end
   end

   // ---------------- directed table ----------------

   typedef struct {
      int                    setup;    // row of solver_setups in force
      logic signed [E_W-1:0] e;
      bit                    last_e;
      bit                    mu_given; // mu typed in below, otherwise predicted
      logic signed [E_W-1:0] mu;
   } energy_row_type;

   typedef struct {
      longint unsigned nel, kt, lim, tol;
   } solver_setup_type;

   solver_setup_type solver_setups[6] = '{
      '{0, 0, 32, 1},                           // reset values, no electrons
      '{64'd8589934592, 0, 32, 1},              // two electrons: all full
      '{64'd4294967296, 0, 32, 1},              // one electron, step occupations
      '{64'd10737418240, 0, 1, 1},              // limit below count: no sign change
      '{64'd4294967296, 64'd1099511627776, 32, 64'd4294967296}, // kT = 256 (top bit of the kT register)
      '{64'd4294967296, 64'd4294967296, 2, 64'd16777216}        // finite kT bisection
   };

   energy_row_type energy_table[14] = '{
      '{0, 48'sd0, 1, 1, -48'sd42949672960000},
      '{0, E_MOST_POS, 0, 0, 0},
      '{0, E_MOST_NEG, 1, 0, 0},
      '{1, 48'sd21474836480, 0, 0, 0},
      '{1, -48'sd12884901888, 1, 1, 48'sd21474836480},
      '{2, -48'sd4294967296, 0, 0, 0},
      '{2, 48'sd4294967296, 1, 0, 0},
      '{3, 48'sd0, 0, 0, 0},
      '{3, 48'sd0, 0, 0, 0},
      '{3, 48'sd0, 1, 1, -48'sd4294967},
      '{4, E_MOST_POS, 1, 1, E_MOST_POS},     // mu2 overflows and clamps
      '{5, -48'sd4294967296, 0, 0, 0},
      '{5, 48'sd0, 0, 0, 0},
      '{5, 48'sd4294967296, 1, 0, 0}
   };

   function automatic logic signed [E_W-1:0] random_energy(bit thermal);
      logic [63:0] w;
      w = {$urandom, $urandom};
      if (thermal) return $signed(w[35:0]) - 48'sd34359738368 / 2;
      if (w[63]) return w[E_W-1:0];
      return $signed({{13{w[34]}}, w[34:0]});
   endfunction

   initial begin
      int setup_now, set_len, budget, sent;
      bit thermal;
      longint unsigned nel, kt, lim, tol;
      fermi_result_type r;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // walk the table, reprogramming between solves when the setup changes
      setup_now = 0;
      foreach (energy_table[i]) begin
         if (energy_table[i].setup != setup_now) begin
            drain_results();
            setup_now = energy_table[i].setup;
            program_solver(solver_setups[setup_now].nel, solver_setups[setup_now].kt,
                           solver_setups[setup_now].lim, solver_setups[setup_now].tol);
         end
         send_energy(energy_table[i].e, energy_table[i].last_e);
         if (energy_table[i].mu_given) begin
            r = pending_results.pop_back();
            r.value = energy_table[i].mu;
            pending_results.push_back(r);
         end
      end
      drain_results();

      // random phases: mostly step occupations, a few short finite-kT sets
      for (int p = 0; p < 12; p++) begin
         thermal = (p % 4 == 3);
         no_gaps = (p % 3 == 1);
         case (p)
            0: begin nel = 0; kt = 0; lim = 32; tol = 1; end
            1: begin nel = 64'd274877906944; kt = 0; lim = 0; tol = 0; end
            2: begin nel = $urandom_range(1, 8) * 64'd4294967296; kt = 0; lim = 32; tol = 0; end
            5: begin nel = 64'd4294967296 * 3; kt = 0; lim = 32; tol = 64'd4294967296; end
            default: begin
               nel = {$urandom_range(0, 15), $urandom} & ((64'd1 << 36) - 1);
               kt = 0;
               lim = $urandom_range(0, 32);
               tol = $urandom_range(0, 3) == 0 ? 64'd4294967296 : $urandom;
            end
         endcase
         if (thermal) begin
            nel = $urandom_range(0, 3) * 64'd2147483648;
            kt = (p == 11) ? 64'd1099511627776 : 64'd1 << $urandom_range(26, 33);
            lim = 32;
            tol = 64'd1 << $urandom_range(26, 32);
         end
         program_solver(nel, kt, lim, tol);
         budget = thermal ? 8 : ((p == 5) ? 60 : 30);
         sent = 0;
         while (sent < budget) begin
            if (thermal) set_len = $urandom_range(1, 3);
            else if (p == 5 && sent == 0) set_len = 40;     // fill the store and hold output
            else if ($urandom_range(0, 7) == 0) set_len = $urandom_range(30, 36);
            else set_len = $urandom_range(1, 8);
            if (p == 5 && sent == 0) hold_rsp = 1'b1;
            for (int k = 0; k < set_len; k++)
               send_energy(random_energy(thermal), k == set_len - 1);
            sent += set_len;
         end
         drain_results();
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   // run limit
   initial begin
      #200ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
